[sv/t0at_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t0at_pkg: shared types and constants for the T=0 command transport
// Opcodes, result kinds, status codes and the input and result item layouts.
// ----------------------------------------------------------------------------
package t0at_pkg;

	localparam int unsigned ResponseMax = 258;
	localparam int unsigned CapLimit = (ResponseMax < 511) ? ResponseMax : 511;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_EMPTY = 2'd2;

	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_BAD_CASE    = 4'd1;
	localparam logic [3:0] ST_NO_RESP     = 4'd2;
	localparam logic [3:0] ST_CASE1_LEN   = 4'd3;
	localparam logic [3:0] ST_PB_60       = 4'd4;
	localparam logic [3:0] ST_ACK_NODATA  = 4'd5;
	localparam logic [3:0] ST_NACK_NODATA = 4'd6;
	localparam logic [3:0] ST_PB_UNKNOWN  = 4'd7;
	localparam logic [3:0] ST_61_NOCASE   = 4'd8;
	localparam logic [3:0] ST_6C_NOCASE   = 4'd9;
	localparam logic [3:0] ST_TD_NOCASE   = 4'd10;
	localparam logic [3:0] ST_TD_NOINS    = 4'd11;
	localparam logic [3:0] ST_TD_OVER     = 4'd12;
	localparam logic [3:0] ST_AD_NOCASE   = 4'd13;
	localparam logic [3:0] ST_AD_OVER     = 4'd14;

	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_CAP  = 1'b1;

	localparam logic [7:0] PB_NULL = 8'h60;
	localparam logic [7:0] SW1_MORE = 8'h61;
	localparam logic [7:0] SW1_LE   = 8'h6C;
	localparam logic [7:0] INS_GETRESP = 8'hC0;
	localparam logic [7:0] SW1_WARN2 = 8'h62;
	localparam logic [7:0] SW1_WARN3 = 8'h63;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [39:0] command_header;
		logic [8:0]  command_length;
		logic [7:0]  response_byte;
		logic        response_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  data_out;
		logic [39:0] tx_header;
		logic        tx_from_command;
		logic [8:0]  tx_offset;
		logic [8:0]  tx_length;
		logic [3:0]  status_code;
		logic [15:0] status_word;
		logic [8:0]  response_length;
	} res_item_t;

	typedef struct packed {
		logic [0:0] index;
		logic [8:0] data;
	} cfg_item_t;

endpackage

[sv/t0at_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t0at_in_if / t0at_res_if / t0at_cfg_if: valid-ready channels
// One interface for each item type, with source and sink views.
// ----------------------------------------------------------------------------
interface t0at_in_if;
	logic valid;
	logic ready;
	t0at_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface t0at_res_if;
	logic valid;
	logic ready;
	t0at_pkg::res_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface t0at_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [8:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/t0at_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t0at_core: per-item exchange logic
// Takes one registered item, updates the exchange state and forms up to two
// result items in the same cycle.
// ----------------------------------------------------------------------------
module t0at_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  t0at_pkg::in_item_t   item,
	input  logic                 mode,
	input  logic [8:0]           cap,
	output logic [1:0]           n_res,
	output t0at_pkg::res_item_t  res0,
	output t0at_pkg::res_item_t  res1
);

	logic [1:0]  case_q;
	logic [39:0] hdr_q;
	logic [8:0]  dptr_q;
	logic        dpend_q;
	logic [8:0]  dend_q;
	logic [15:0] held_q;
	logic        srec_q;
	logic [8:0]  bidx_q;
	logic [15:0] delay_q;
	logic [8:0]  dcnt_q;
	logic [1:0]  eflg_q;
	logic        act_q;

	logic [1:0]  case_d;
	logic [39:0] hdr_d;
	logic [8:0]  dptr_d;
	logic        dpend_d;
	logic [8:0]  dend_d;
	logic [15:0] held_d;
	logic        srec_d;
	logic [8:0]  bidx_d;
	logic [15:0] delay_d;
	logic [8:0]  dcnt_d;
	logic [1:0]  eflg_d;
	logic        act_d;

	logic [8:0] cap_eff;
	always_comb begin
		cap_eff = cap;
		if (cap > 9'(t0at_pkg::CapLimit)) cap_eff = 9'(t0at_pkg::CapLimit);
		if (cap < 9'd2) cap_eff = 9'd2;
	end

	function automatic t0at_pkg::res_item_t mk_done(logic [3:0] st, logic [7:0] d,
			logic [15:0] sw, logic [8:0] rl);
		t0at_pkg::res_item_t r;
		r = '0;
		r.result_kind = t0at_pkg::KIND_DONE;
		r.data_out = d;
		r.status_code = st;
		r.status_word = sw;
		r.response_length = rl;
		return r;
	endfunction

	function automatic t0at_pkg::res_item_t mk_hdr(logic [39:0] h);
		t0at_pkg::res_item_t r;
		r = '0;
		r.result_kind = t0at_pkg::KIND_TX;
		r.tx_header = h;
		r.tx_length = 9'd5;
		return r;
	endfunction

	function automatic t0at_pkg::res_item_t mk_cmd(logic [8:0] off, logic [8:0] len);
		t0at_pkg::res_item_t r;
		r = '0;
		r.result_kind = t0at_pkg::KIND_TX;
		r.tx_from_command = 1'b1;
		r.tx_offset = off;
		r.tx_length = len;
		return r;
	endfunction

	always_comb begin
		logic [7:0]  p3, b, ins, sw1, sw2, le;
		logic [9:0]  p3p5, p3p6;
		logic [1:0]  cc;
		logic        cc_ok, c24, get_resp, upd_le, fin, hdr_out, stop;
		logic [8:0]  n, kidx, rem;
		logic [9:0]  remaining;
		logic [15:0] sw_now;
		t0at_pkg::res_item_t r;
		logic        have_data;

		case_d = case_q; hdr_d = hdr_q; dptr_d = dptr_q; dpend_d = dpend_q;
		dend_d = dend_q; held_d = held_q; srec_d = srec_q; bidx_d = bidx_q;
		delay_d = delay_q; dcnt_d = dcnt_q; eflg_d = eflg_q; act_d = act_q;
		n_res = 2'd0; res0 = '0; res1 = '0;
		p3 = item.command_header[7:0];
		b = item.response_byte;
		ins = hdr_q[31:24];
		p3p5 = 10'(p3) + 10'd5;
		p3p6 = 10'(p3) + 10'd6;
		cc = 2'd0; cc_ok = 1'b1;
		c24 = case_q[0];
		get_resp = 1'b0; upd_le = 1'b0; fin = 1'b0; hdr_out = 1'b0; stop = 1'b0;
		n = '0; kidx = bidx_q; rem = '0; remaining = '0; sw_now = '0; le = '0;
		sw1 = '0; sw2 = '0; r = '0; have_data = 1'b0;

		if (go) begin
			unique case (item.opcode)
				t0at_pkg::OP_START: begin
					held_d = '0; srec_d = 1'b0; dcnt_d = '0; dpend_d = 1'b0;
					dptr_d = 9'd5; bidx_d = '0; delay_d = '0; eflg_d = '0;
					priority if (item.command_length == 9'd4) cc = 2'd0;
					else if (item.command_length == 9'd5) cc = 2'd1;
					else if (p3 != 8'd0 && {1'b0, item.command_length} == p3p5) cc = 2'd2;
					else if (p3 != 8'd0 && {1'b0, item.command_length} == p3p6) cc = 2'd3;
					else cc_ok = 1'b0;
					if (!cc_ok) begin
						act_d = 1'b0;
						res0 = mk_done(t0at_pkg::ST_BAD_CASE, '0, '0, '0);
						n_res = 2'd1;
					end else begin
						case_d = cc;
						act_d = 1'b1;
						dend_d = p3p5[8:0];
						hdr_d = item.command_header;
						if (cc == 2'd0) hdr_d[7:0] = 8'd0;
						if (!mode) begin
							res0 = mk_cmd('0, item.command_length);
						end else begin
							dpend_d = cc[1];
							res0 = mk_hdr(hdr_d);
						end
						n_res = 2'd1;
					end
				end
				t0at_pkg::OP_EMPTY: begin
					if (act_q) begin
						res0 = mk_done(t0at_pkg::ST_NO_RESP, '0, srec_q ? held_q : 16'd0, '0);
						n_res = 2'd1;
						act_d = 1'b0; bidx_d = '0; delay_d = '0; eflg_d = '0;
					end
				end
				t0at_pkg::OP_BYTE: begin
					if (act_q) begin
						if (kidx == 9'd0 && b != ins) eflg_d[0] = 1'b1;
						if (c24 && ((mode && kidx >= 9'd3) || (!mode && kidx >= 9'd2)))
							have_data = 1'b1;
						delay_d = {delay_q[7:0], b};
						if (kidx < 9'd511) bidx_d = kidx + 9'd1;
						else eflg_d[1] = 1'b1;
						if (item.response_last) begin
							n = bidx_d;
							sw1 = (n >= 9'd2) ? delay_q[7:0] : b;
							sw2 = (n >= 9'd2) ? b : 8'hFF;
							sw_now = {sw1, sw2};
							if (case_q == 2'd0) begin
								fin = 1'b1;
								if (n != 9'd2) begin
									r = mk_done(t0at_pkg::ST_CASE1_LEN, '0,
										srec_q ? held_q : 16'd0, '0);
								end else begin
									held_d = sw_now; srec_d = 1'b1;
									r = mk_done(t0at_pkg::ST_OK, '0, sw_now, 9'd2);
								end
							end else if (n == 9'd1) begin
								priority if (b == t0at_pkg::PB_NULL) begin
									fin = 1'b1;
									r = mk_done(t0at_pkg::ST_PB_60, b, srec_q ? held_q : 16'd0, 9'd1);
								end else if (b == ins) begin
									if (!dpend_q) begin
										fin = 1'b1;
										r = mk_done(t0at_pkg::ST_ACK_NODATA, b,
											srec_q ? held_q : 16'd0, 9'd1);
									end else begin
										rem = (dend_q > dptr_q) ? dend_q - dptr_q : 9'd1;
										r = mk_cmd(dptr_q, rem);
										dptr_d = dend_q; dpend_d = 1'b0;
										bidx_d = '0; delay_d = '0; eflg_d = '0;
									end
								end else if (b == ~ins) begin
									if (!dpend_q) begin
										fin = 1'b1;
										r = mk_done(t0at_pkg::ST_NACK_NODATA, b,
											srec_q ? held_q : 16'd0, 9'd1);
									end else begin
										r = mk_cmd(dptr_q, 9'd1);
										dptr_d = dptr_q + 9'd1;
										if (dptr_d >= dend_q) dpend_d = 1'b0;
										bidx_d = '0; delay_d = '0; eflg_d = '0;
									end
								end else begin
									fin = 1'b1;
									r = mk_done(t0at_pkg::ST_PB_UNKNOWN, b,
										srec_q ? held_q : 16'd0, 9'd1);
								end
							end else begin
								if (sw1 == t0at_pkg::SW1_MORE) begin
									if (!c24) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_61_NOCASE, '0,
											srec_q ? held_q : 16'd0, '0);
									end
									get_resp = 1'b1;
								end else if (sw1 == t0at_pkg::SW1_LE) begin
									if (!c24) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_6C_NOCASE, '0,
											srec_q ? held_q : 16'd0, '0);
									end
									upd_le = 1'b1;
								end else if (!srec_q) begin
									held_d = sw_now; srec_d = 1'b1;
									if (case_q == 2'd3 && n == 9'd2 &&
											(sw1 == t0at_pkg::SW1_WARN2 || sw1 == t0at_pkg::SW1_WARN3))
										get_resp = 1'b1;
								end
								remaining = 10'(cap_eff) - 10'(dcnt_q);
								if (!stop && mode && n > 9'd3) begin
									if (!c24) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_TD_NOCASE, '0, srec_d ? held_d : 16'd0, '0);
									end else if (eflg_d[0]) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_TD_NOINS, '0, srec_d ? held_d : 16'd0, '0);
									end else if (eflg_d[1] || remaining < 10'(n) - 10'd1) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_TD_OVER, '0, srec_d ? held_d : 16'd0, '0);
									end else dcnt_d = dcnt_q + n - 9'd3;
								end
								if (!stop && !mode && n > 9'd2) begin
									if (!c24) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_AD_NOCASE, '0, srec_d ? held_d : 16'd0, '0);
									end else if (eflg_d[1] || remaining < 10'(n)) begin
										stop = 1'b1;
										r = mk_done(t0at_pkg::ST_AD_OVER, '0, srec_d ? held_d : 16'd0, '0);
									end else dcnt_d = dcnt_q + n - 9'd2;
								end
								if (stop) begin
									fin = 1'b1;
								end else if (get_resp) begin
									le = (sw1 == t0at_pkg::SW1_MORE || (sw1 == t0at_pkg::SW1_WARN2 &&
										sw2 >= 8'h02 && sw2 <= 8'h80)) ? sw2 : 8'd0;
									hdr_out = 1'b1;
									hdr_d = {8'd0, t0at_pkg::INS_GETRESP, 16'd0, le};
									r = mk_hdr(hdr_d);
								end else if (upd_le) begin
									hdr_out = 1'b1;
									hdr_d = {hdr_q[39:8], sw2};
									r = mk_hdr(hdr_d);
								end else begin
									fin = 1'b1;
									r = mk_done(t0at_pkg::ST_OK, '0, srec_d ? held_d : 16'd0,
										dcnt_d + 9'd2);
								end
							end
							if (fin) begin
								act_d = 1'b0; bidx_d = '0; delay_d = '0; eflg_d = '0;
							end
							if (hdr_out) begin
								bidx_d = '0; delay_d = '0; eflg_d = '0;
							end
						end
						if (have_data) begin
							res0 = '0;
							res0.result_kind = t0at_pkg::KIND_DATA;
							res0.data_out = delay_q[15:8];
							if (item.response_last) begin
								res1 = r; n_res = 2'd2;
							end else n_res = 2'd1;
						end else if (item.response_last) begin
							res0 = r; n_res = 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_q <= '0; hdr_q <= '0; dptr_q <= '0; dpend_q <= 1'b0; dend_q <= '0;
			held_q <= '0; srec_q <= 1'b0; bidx_q <= '0; delay_q <= '0; dcnt_q <= '0;
			eflg_q <= '0; act_q <= 1'b0;
		end else begin
			case_q <= case_d; hdr_q <= hdr_d; dptr_q <= dptr_d; dpend_q <= dpend_d;
			dend_q <= dend_d; held_q <= held_d; srec_q <= srec_d; bidx_q <= bidx_d;
			delay_q <= delay_d; dcnt_q <= dcnt_d; eflg_q <= eflg_d; act_q <= act_d;
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |-> bidx_q == 9'd0)
		else $error("byte count left over with no exchange active");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= 9'(t0at_pkg::CapLimit))
		else $error("data count above capacity");
	a_ptr_end: assert property (@(posedge clk) disable iff (!arst_n)
		dpend_q |-> dptr_q < dend_q)
		else $error("data pending past end of command");

endmodule

[sv/t0at_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t0at_out: result queue
// Four-entry queue holding result items until the sink takes them.
// ----------------------------------------------------------------------------
module t0at_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 inflight,
	input  logic [1:0]           n_push,
	input  t0at_pkg::res_item_t  push0,
	input  t0at_pkg::res_item_t  push1,
	output logic                 room2,
	t0at_res_if.source           res
);

	t0at_pkg::res_item_t buf_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = res.valid && res.ready;
	assign res.valid = cnt_q != 3'd0;
	assign res.payload = buf_q[rd_q];
	// Reserve two slots for the item in the input register and two for the next one,
	// counting this cycle's pop.
	assign room2 = (4'(cnt_q) + (inflight ? 4'd2 : 4'd0)) <= (4'd2 + 4'(pop));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) buf_q[wr_q] <= push0;
		if (n_push == 2'd2) buf_q[wr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(n_push) - 3'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("result queue overflow");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		n_push != 2'd0 |-> $past(room2) || cnt_q <= 3'd4)
		else $error("push without room");

endmodule

[sv/t0_apdu_transport_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t0_apdu_transport_top: T=0 command exchange transport
// Channel  Dir  Carries
// cmd      in   opcode, header, length, card byte, last flag
// rsp      out  transmit descriptors, response data, finish status
// cfg      in   register index and data (mode, capacity)
// One item a cycle while the result queue has room: input register, then exchange
// logic that pushes up to two results into a four-entry result queue.
// Input is taken only while the queue, after this cycle's pop, can hold two
// results of the item in the input register and two of the next one.
// Reset is asynchronous, no clearing pass.
// ----------------------------------------------------------------------------
module t0_apdu_transport_top (
	input  logic        clk,
	input  logic        arst_n,
	t0at_in_if.sink     cmd,
	t0at_res_if.source  rsp,
	t0at_cfg_if.sink    cfg
);

	t0at_pkg::in_item_t item_s1;
	logic               go_s1;
	logic               mode_q;
	logic [8:0]         cap_q;
	logic [1:0]         n_res;
	t0at_pkg::res_item_t r0, r1;
	logic               room2;

	// room2 accounts for the item already in the input register.
	assign cmd.ready = room2;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) item_s1 <= cmd.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0; mode_q <= 1'b1; cap_q <= 9'd258;
		end else begin
			go_s1 <= cmd.valid && cmd.ready;
			if (cfg.valid) begin
				if (cfg.index == {1'b0, t0at_pkg::REG_MODE}) mode_q <= cfg.data[0];
				else if (cfg.index == {1'b0, t0at_pkg::REG_CAP}) cap_q <= cfg.data;
			end
		end
	end

	t0at_core u_core (
		.clk(clk), .arst_n(arst_n), .go(go_s1), .item(item_s1),
		.mode(mode_q), .cap(cap_q), .n_res(n_res), .res0(r0), .res1(r1)
	);

	t0at_out u_out (
		.clk(clk), .arst_n(arst_n), .inflight(go_s1), .n_push(n_res), .push0(r0),
		.push1(r1), .room2(room2), .res(rsp)
	);

endmodule
